FILE: hdl/tcp_payload_pattern_blocker_macros.svh
// assertion helpers shared by the blocker rtl
`ifndef TCP_PAYLOAD_PATTERN_BLOCKER_MACROS_SVH
`define TCP_PAYLOAD_PATTERN_BLOCKER_MACROS_SVH

// condition that must hold at every edge out of reset
`define TPB_ASSERT_NOW(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("tpb check failed");

// implication checked at every edge out of reset
`define TPB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tpb check failed");

`endif

FILE: hdl/tpb_pkg.sv
package tpb_pkg;

  // frame layout
  localparam int unsigned EthHdrBytes   = 14;
  localparam int unsigned MinFrameBytes = 54;
  localparam int unsigned PatMaxBytes   = 8;
  localparam logic [15:0] EtherIpv4     = 16'h0800;
  localparam logic [7:0]  ProtoTcp      = 8'd6;
  localparam logic [15:0] PosMax        = 16'hffff;

  // match starts recorded before the payload start is known
  localparam int unsigned PendBits  = 72;
  localparam int unsigned PendFirst = EthHdrBytes;
  localparam int unsigned PendLast  = EthHdrBytes + PendBits - 1;

  // register map
  localparam logic RegPattern = 1'b0;
  localparam logic RegLength  = 1'b1;

  typedef enum logic [2:0] {
    VerdictPass      = 3'd0,
    VerdictBlock     = 3'd1,
    VerdictShort     = 3'd2,
    VerdictNotIpv4   = 3'd3,
    VerdictNotTcp    = 3'd4,
    VerdictNoPayload = 3'd5
  } verdict_e;

  // per-frame summary handed from the parser to the verdict stage
  typedef struct packed {
    logic                short_frame;
    logic [15:0]         ether_type;
    logic [3:0]          ihl;
    logic [3:0]          tcp_off;
    logic [15:0]         ip_total;
    logic [7:0]          proto;
    logic [7:0]          ttl;
    logic [31:0]         src_addr;
    logic [31:0]         dst_addr;
    logic [31:0]         ports;
    logic [31:0]         seq;
    logic [31:0]         ack;
    logic [PendBits-1:0] pend;
    logic                direct_hit;
  } tpb_rec_t;

  typedef struct packed {
    logic full;
    logic valid;
  } tpb_qstat_t;

  // pattern bytes in use
  function automatic logic [3:0] used_len(input logic [3:0] len);
    logic [3:0] n;
    n = len;
    if (n > 4'(PatMaxBytes)) n = 4'(PatMaxBytes);
    return n;
  endfunction

endpackage

FILE: hdl/tpb_front.sv
module tpb_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       frame_byte_i,
  input  logic             end_of_frame_i,
  input  logic [63:0]      pattern_i,
  input  logic [3:0]       pat_len_i,
  input  tpb_pkg::tpb_qstat_t q_stat_i,
  output logic             push_o,
  output tpb_pkg::tpb_rec_t push_rec_o
);
  import tpb_pkg::*;

  tpb_rec_t    st_q, st_d;
  logic [15:0] pos_q, pos_d;
  logic [63:0] win_q, win_d;

  logic        accept, store;
  logic [3:0]  ihl_eff, off_eff, n;
  logic [7:0]  tcp_start, first;
  logic [15:0] rel;
  logic [63:0] win_next, shifted, mask;
  logic        hit;
  logic [16:0] s;
  logic [16:0] stop;
  logic [6:0]  pidx;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i & ~in_stall_o;
  assign store      = (pos_q != PosMax);
  assign n          = used_len(pat_len_i);

  // tcp header position, ihl taken from the byte itself when it is arriving
  assign ihl_eff   = (pos_q == 16'(EthHdrBytes)) ? frame_byte_i[3:0] : st_q.ihl;
  assign tcp_start = 8'(EthHdrBytes) + {2'b00, ihl_eff, 2'b00};
  assign rel       = pos_q - {8'd0, tcp_start};
  // data offset taken from the byte itself when it is arriving
  assign off_eff   = (pos_q == {8'd0, tcp_start} + 16'd12) ? frame_byte_i[7:4] : st_q.tcp_off;
  assign first     = 8'(EthHdrBytes) + {2'b00, st_q.ihl, 2'b00} + {2'b00, off_eff, 2'b00};
  assign stop      = 17'(EthHdrBytes) + {1'b0, st_q.ip_total};

  // sliding window compare on the newest bytes
  assign win_next = {frame_byte_i, win_q[63:8]};
  assign shifted  = win_next >> {4'(4'd8 - n), 3'b000};
  assign mask     = (n == 4'd8) ? '1 : ((64'd1 << {n, 3'b000}) - 64'd1);
  assign hit      = (n != 4'd0) && (shifted == (pattern_i & mask));
  assign s        = {1'b0, pos_q} + 17'd1 - {13'd0, n};
  assign pidx     = 7'(s - 17'(PendFirst));

  always_comb begin
    st_d       = st_q;
    pos_d      = pos_q;
    win_d      = win_q;
    push_o     = 1'b0;
    push_rec_o = st_q;
    if (accept) begin
      if (store) begin
        pos_d = pos_q + 16'd1;
        win_d = win_next;
        // ethernet and ip header fields
        case (pos_q)
          16'd12:  st_d.ether_type[15:8] = frame_byte_i;
          16'd13:  st_d.ether_type[7:0]  = frame_byte_i;
          16'd14:  st_d.ihl              = frame_byte_i[3:0];
          16'd16:  st_d.ip_total[15:8]   = frame_byte_i;
          16'd17:  st_d.ip_total[7:0]    = frame_byte_i;
          16'd22:  st_d.ttl              = frame_byte_i;
          16'd23:  st_d.proto            = frame_byte_i;
          16'd26:  st_d.src_addr[31:24]  = frame_byte_i;
          16'd27:  st_d.src_addr[23:16]  = frame_byte_i;
          16'd28:  st_d.src_addr[15:8]   = frame_byte_i;
          16'd29:  st_d.src_addr[7:0]    = frame_byte_i;
          16'd30:  st_d.dst_addr[31:24]  = frame_byte_i;
          16'd31:  st_d.dst_addr[23:16]  = frame_byte_i;
          16'd32:  st_d.dst_addr[15:8]   = frame_byte_i;
          16'd33:  st_d.dst_addr[7:0]    = frame_byte_i;
          default: ;
        endcase
        // tcp header fields
        if (pos_q >= {8'd0, tcp_start} && rel < 16'd13) begin
          case (rel[3:0])
            4'd0:    st_d.ports[31:24]  = frame_byte_i;
            4'd1:    st_d.ports[23:16]  = frame_byte_i;
            4'd2:    st_d.ports[15:8]   = frame_byte_i;
            4'd3:    st_d.ports[7:0]    = frame_byte_i;
            4'd4:    st_d.seq[31:24]    = frame_byte_i;
            4'd5:    st_d.seq[23:16]    = frame_byte_i;
            4'd6:    st_d.seq[15:8]     = frame_byte_i;
            4'd7:    st_d.seq[7:0]      = frame_byte_i;
            4'd8:    st_d.ack[31:24]    = frame_byte_i;
            4'd9:    st_d.ack[23:16]    = frame_byte_i;
            4'd10:   st_d.ack[15:8]     = frame_byte_i;
            4'd11:   st_d.ack[7:0]      = frame_byte_i;
            4'd12:   st_d.tcp_off       = frame_byte_i[7:4];
            default: ;
          endcase
        end
        // record the match, early starts go to the pending map
        if (hit && ({1'b0, pos_q} + 17'd1 >= {13'd0, n})) begin
          if (s >= 17'(PendFirst) && s <= 17'(PendLast)) begin
            st_d.pend[pidx] = 1'b1;
          end else if (s > 17'(PendLast) && s >= {9'd0, first} && {1'b0, pos_q} < stop) begin
            st_d.direct_hit = 1'b1;
          end
        end
      end
      // end of frame: hand off the summary and restart
      if (end_of_frame_i) begin
        push_o                 = 1'b1;
        push_rec_o             = st_d;
        push_rec_o.short_frame = (pos_d < 16'(MinFrameBytes));
        st_d                   = '0;
        pos_d                  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '0;
      pos_q <= '0;
      win_q <= '0;
    end else begin
      st_q  <= st_d;
      pos_q <= pos_d;
      win_q <= win_d;
    end
  end

endmodule

FILE: hdl/tpb_queue.sv
module tpb_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tpb_pkg::tpb_rec_t  push_rec_i,
  input  logic               pop_i,
  output tpb_pkg::tpb_rec_t  head_o,
  output tpb_pkg::tpb_qstat_t stat_o
);
  import tpb_pkg::*;

  tpb_rec_t    mem [4];
  logic [1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        do_pop;

  assign stat_o.full  = (cnt_q == 3'd4);
  assign stat_o.valid = (cnt_q != 3'd0);
  assign head_o       = mem[rd_q];
  assign do_pop       = pop_i & stat_o.valid;

  // pointer and fill count update
  always_comb begin
    wr_d  = wr_q + {1'b0, push_i};
    rd_d  = rd_q + {1'b0, do_pop};
    cnt_d = cnt_q + {2'b00, push_i} - {2'b00, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= push_rec_i;
    end
  end

endmodule

FILE: hdl/tpb_back.sv
module tpb_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tpb_pkg::tpb_rec_t head_i,
  input  logic              head_valid_i,
  output logic              pop_o,
  input  logic [3:0]        pat_len_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        verdict_o,
  output logic [31:0]       reply_sequence_o,
  output logic [31:0]       acknowledge_number_o,
  output logic [31:0]       source_address_o,
  output logic [31:0]       destination_address_o,
  output logic [15:0]       source_port_o,
  output logic [15:0]       destination_port_o,
  output logic [7:0]        hop_limit_o,
  output logic [15:0]       payload_length_o
);
  import tpb_pkg::*;

  logic        valid_q, valid_d;
  verdict_e    verdict_q, verdict_d;
  logic [31:0] rseq_q, ack_q, src_q, dst_q;
  logic [15:0] sport_q, dport_q, plen_q, plen_d;
  logic [7:0]  ttl_q;

  logic [3:0]          n;
  logic [6:0]          hdr;
  logic [17:0]         diff;
  logic                pay_pos;
  logic [PendBits-1:0] pend_ok;
  logic                found;

  assign n     = used_len(pat_len_i);
  assign pop_o = head_valid_i & (~valid_q | ~out_stall_i);

  // payload length from the ip header
  assign hdr     = {1'b0, head_i.ihl, 2'b00} + {1'b0, head_i.tcp_off, 2'b00};
  assign diff    = {2'b00, head_i.ip_total} - {11'd0, hdr};
  assign pay_pos = ~diff[17] & (diff != 18'd0);
  assign plen_d  = pay_pos ? diff[15:0] : 16'd0;

  // pending matches that fall inside the payload span
  always_comb begin
    for (int k = 0; k < PendBits; k++) begin
      pend_ok[k] = head_i.pend[k] && (7'(k) >= hdr)
                   && (17'(k) + {13'd0, n} <= {1'b0, head_i.ip_total});
    end
  end
  assign found = head_i.direct_hit | (|pend_ok);

  // verdict priority
  always_comb begin
    if (head_i.short_frame)                verdict_d = VerdictShort;
    else if (head_i.ether_type != EtherIpv4) verdict_d = VerdictNotIpv4;
    else if (head_i.proto != ProtoTcp)     verdict_d = VerdictNotTcp;
    else if (!pay_pos)                     verdict_d = VerdictNoPayload;
    else if (found)                        verdict_d = VerdictBlock;
    else                                   verdict_d = VerdictPass;
  end

  always_comb begin
    valid_d = valid_q;
    if (pop_o)            valid_d = 1'b1;
    else if (!out_stall_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      verdict_q <= verdict_d;
      rseq_q    <= head_i.seq + {16'd0, plen_d};
      ack_q     <= head_i.ack;
      src_q     <= head_i.src_addr;
      dst_q     <= head_i.dst_addr;
      sport_q   <= head_i.ports[31:16];
      dport_q   <= head_i.ports[15:0];
      ttl_q     <= head_i.ttl;
      plen_q    <= plen_d;
    end
  end

  assign out_valid_o           = valid_q;
  assign verdict_o             = verdict_q;
  assign reply_sequence_o      = rseq_q;
  assign acknowledge_number_o  = ack_q;
  assign source_address_o      = src_q;
  assign destination_address_o = dst_q;
  assign source_port_o         = sport_q;
  assign destination_port_o    = dport_q;
  assign hop_limit_o           = ttl_q;
  assign payload_length_o      = plen_q;

endmodule

FILE: hdl/tcp_payload_pattern_blocker.sv
// channel   direction  handshake                 payload
// frame     in         in_valid_i / in_stall_o   frame_byte_i, end_of_frame_i
// result    out        out_valid_o / out_stall_i verdict_o and reply fields
// config    in         apb psel/penable/pwrite   pattern (0x0), length (0x8)
//
// one frame byte per cycle, back to back while in_stall_o is low, set by the byte parser
// a result leaves after the last byte through a four-entry summary queue and the result register
// in_stall_o rises only while that queue is full
// reset clears parser state, queue pointers and the result valid

`include "tcp_payload_pattern_blocker_macros.svh"

module tcp_payload_pattern_blocker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        end_of_frame_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  verdict_o,
  output logic [31:0] reply_sequence_o,
  output logic [31:0] acknowledge_number_o,
  output logic [31:0] source_address_o,
  output logic [31:0] destination_address_o,
  output logic [15:0] source_port_o,
  output logic [15:0] destination_port_o,
  output logic [7:0]  hop_limit_o,
  output logic [15:0] payload_length_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import tpb_pkg::*;

  logic [63:0] pattern_q;
  logic [3:0]  len_q;
  logic        cfg_wr;

  logic       q_push, q_pop;
  tpb_rec_t   push_rec, head;
  tpb_qstat_t q_stat;
  logic       out_pay_verdict;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[3] == RegLength) ? {60'd0, len_q} : pattern_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      len_q     <= '0;
    end else if (cfg_wr) begin
      if (paddr[3] == RegPattern) pattern_q <= pwdata;
      else                        len_q     <= pwdata[3:0];
    end
  end

  tpb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .frame_byte_i   (frame_byte_i),
    .end_of_frame_i (end_of_frame_i),
    .pattern_i      (pattern_q),
    .pat_len_i      (len_q),
    .q_stat_i       (q_stat),
    .push_o         (q_push),
    .push_rec_o     (push_rec)
  );

  tpb_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_rec_i (push_rec),
    .pop_i      (q_pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  tpb_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .head_i                (head),
    .head_valid_i          (q_stat.valid),
    .pop_o                 (q_pop),
    .pat_len_i             (len_q),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .verdict_o             (verdict_o),
    .reply_sequence_o      (reply_sequence_o),
    .acknowledge_number_o  (acknowledge_number_o),
    .source_address_o      (source_address_o),
    .destination_address_o (destination_address_o),
    .source_port_o         (source_port_o),
    .destination_port_o    (destination_port_o),
    .hop_limit_o           (hop_limit_o),
    .payload_length_o      (payload_length_o)
  );

  // verdicts that only come with a payload
  assign out_pay_verdict = (verdict_o == VerdictPass) || (verdict_o == VerdictBlock);

  // checks
  `TPB_ASSERT_NOW(a_no_push_when_full, !(q_push && q_stat.full))
  `TPB_ASSERT_IMP(a_pass_has_payload, out_valid_o && out_pay_verdict, payload_length_o != 16'd0)
  `TPB_ASSERT_IMP(a_pop_needs_entry, q_pop, q_stat.valid)

endmodule
